>>> src/ptl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptl_pkg
// Shared types, codes and per-byte lexing functions of the PDF token lexer.
// ---------------------------------------------------------------------------
package ptl_pkg;

  localparam logic [7:0] MAX_DEPTH = 8'd255;
  localparam int         NOUT      = 5;

  // token modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_NAME    = 4'd2;
  localparam logic [3:0] M_CAND    = 4'd3;
  localparam logic [3:0] M_KEYWORD = 4'd4;
  localparam logic [3:0] M_STR     = 4'd5;
  localparam logic [3:0] M_STR_ESC = 4'd6;
  localparam logic [3:0] M_STR_CR  = 4'd7;
  localparam logic [3:0] M_STR_OCT = 4'd8;
  localparam logic [3:0] M_LT      = 4'd9;
  localparam logic [3:0] M_GT      = 4'd10;
  localparam logic [3:0] M_HEX     = 4'd11;

  // token types
  localparam logic [3:0] T_NUMBER     = 4'd0;
  localparam logic [3:0] T_KEYWORD    = 4'd1;
  localparam logic [3:0] T_NAME       = 4'd2;
  localparam logic [3:0] T_STRING     = 4'd3;
  localparam logic [3:0] T_ARR_START  = 4'd4;
  localparam logic [3:0] T_ARR_END    = 4'd5;
  localparam logic [3:0] T_DICT_START = 4'd6;
  localparam logic [3:0] T_DICT_END   = 4'd7;
  localparam logic [3:0] T_EOF        = 4'd8;

  // input kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       ev;
    logic [3:0] ttype;
    logic [7:0] cbyte;
    logic       integ;
  } res_t;

  typedef struct packed {
    res_t [NOUT-1:0] r;
    logic [2:0]      cnt;
  } list_t;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] depth;
    logic [1:0] flags;   // bit0 digit seen, bit1 dot seen
    logic [7:0] escv;
    logic [1:0] escn;
    logic [4:0] nib;     // bit4 valid
    logic [9:0] pname;   // bits9..8 held count
  } state_t;

  typedef struct packed {
    state_t st;
    list_t  l;
  } work_t;

  function automatic logic is_ws(logic [7:0] c);
    return c == 8'h00 || c == 8'h09 || c == 8'h0A || c == 8'h0C || c == 8'h0D || c == 8'h20;
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return c == "(" || c == ")" || c == "<" || c == ">" || c == "[" || c == "]" ||
           c == "{" || c == "}" || c == "/" || c == "%";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // bit4 set when c is a hex digit, bits3..0 its value
  function automatic logic [4:0] hexv(logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "0" && c <= "9") v = c - 8'h30;
    else if (c >= "a" && c <= "f") v = c - 8'h57;
    else if (c >= "A" && c <= "F") v = c - 8'h37;
    else return 5'd0;
    return {1'b1, v[3:0]};
  endfunction

  function automatic work_t put(work_t w, logic ev, logic [3:0] t, logic [7:0] b, logic i);
    if (w.l.cnt < 3'(NOUT)) begin
      w.l.r[w.l.cnt] = '{ev: ev, ttype: t, cbyte: b, integ: i};
      w.l.cnt = w.l.cnt + 3'd1;
    end
    return w;
  endfunction

  function automatic work_t content(work_t w, logic [3:0] t, logic [7:0] b);
    return put(w, 1'b0, t, b, 1'b0);
  endfunction

  function automatic work_t done(work_t w, logic [3:0] t);
    return put(w, 1'b1, t, 8'd0, 1'b0);
  endfunction

  function automatic work_t name_flush(work_t w);
    if (w.st.pname[9:8] >= 2'd1) w = content(w, T_NAME, "#");
    if (w.st.pname[9:8] == 2'd2) w = content(w, T_NAME, w.st.pname[7:0]);
    w.st.pname = 10'd0;
    return w;
  endfunction

  function automatic work_t name_char(work_t w, logic [7:0] c);
    logic [4:0] hc;
    logic [4:0] hh;
    hc = hexv(c);
    hh = hexv(w.st.pname[7:0]);
    if (w.st.pname[9:8] == 2'd1 && hc[4]) begin
      w.st.pname = {2'd2, c};
    end else if (w.st.pname[9:8] == 2'd2 && hc[4]) begin
      w = content(w, T_NAME, {hh[3:0], hc[3:0]});
      w.st.pname = 10'd0;
    end else begin
      w = name_flush(w);
      if (c == "#") w.st.pname = {2'd1, 8'd0};
      else w = content(w, T_NAME, c);
    end
    return w;
  endfunction

  function automatic work_t dispatch(work_t w, logic [7:0] c);
    w.st.mode  = M_IDLE;
    w.st.flags = 2'd0;
    if (is_ws(c) || c == ")") begin
    end else if (c == "%") begin
      w.st.mode = M_COMMENT;
    end else if (c == "/") begin
      w.st.mode  = M_NAME;
      w.st.pname = 10'd0;
    end else if (c == "(") begin
      w.st.mode  = M_STR;
      w.st.depth = 8'd1;
    end else if (c == "<") begin
      w.st.mode = M_LT;
    end else if (c == ">") begin
      w.st.mode = M_GT;
    end else if (c == "[") begin
      w = done(w, T_ARR_START);
    end else if (c == "]") begin
      w = done(w, T_ARR_END);
    end else if (c == "{" || c == "}") begin
      w = content(w, T_KEYWORD, c);
      w = done(w, T_KEYWORD);
    end else if (c == "+" || c == "-") begin
      w.st.mode = M_CAND;
      w = content(w, T_NUMBER, c);
    end else if (is_digit(c)) begin
      w.st.mode  = M_CAND;
      w.st.flags = 2'd1;
      w = content(w, T_NUMBER, c);
    end else if (c == ".") begin
      w.st.mode  = M_CAND;
      w.st.flags = 2'd2;
      w = content(w, T_NUMBER, c);
    end else begin
      w.st.mode = M_KEYWORD;
      w = content(w, T_KEYWORD, c);
    end
    return w;
  endfunction

  function automatic work_t str_char(work_t w, logic [7:0] c);
    w.st.mode = M_STR;
    if (c == "\\") begin
      w.st.mode = M_STR_ESC;
    end else if (c == "(") begin
      if (w.st.depth < MAX_DEPTH) w.st.depth = w.st.depth + 8'd1;
      w = content(w, T_STRING, c);
    end else if (c == ")") begin
      if (w.st.depth > 8'd0) w.st.depth = w.st.depth - 8'd1;
      if (w.st.depth > 8'd0) begin
        w = content(w, T_STRING, c);
      end else begin
        w = done(w, T_STRING);
        w.st.mode = M_IDLE;
      end
    end else begin
      w = content(w, T_STRING, c);
    end
    return w;
  endfunction

  function automatic work_t str_escape(work_t w, logic [7:0] c);
    w.st.mode = M_STR;
    case (c)
      "n":   w = content(w, T_STRING, 8'h0A);
      "r":   w = content(w, T_STRING, 8'h0D);
      "t":   w = content(w, T_STRING, 8'h09);
      "b":   w = content(w, T_STRING, 8'h08);
      "f":   w = content(w, T_STRING, 8'h0C);
      8'h0D: w.st.mode = M_STR_CR;
      8'h0A: w.st.mode = M_STR;
      default: begin
        if (c >= "0" && c <= "7") begin
          w.st.escv = {5'd0, c[2:0]};
          w.st.escn = 2'd1;
          w.st.mode = M_STR_OCT;
        end else begin
          w = content(w, T_STRING, c);
        end
      end
    endcase
    return w;
  endfunction

  function automatic work_t hex_char(work_t w, logic [7:0] c);
    logic [4:0] hc;
    hc = hexv(c);
    if (c == ">") begin
      if (w.st.nib[4]) w = content(w, T_STRING, {w.st.nib[3:0], 4'd0});
      w.st.nib  = 5'd0;
      w = done(w, T_STRING);
      w.st.mode = M_IDLE;
    end else if (hc[4]) begin
      if (w.st.nib[4]) begin
        w = content(w, T_STRING, {w.st.nib[3:0], hc[3:0]});
        w.st.nib = 5'd0;
      end else begin
        w.st.nib = hc;
      end
    end
    return w;
  endfunction

  function automatic work_t byte_in(work_t w, logic [7:0] c);
    case (w.st.mode)
      M_COMMENT: begin
        if (c == 8'h0A || c == 8'h0D) w.st.mode = M_IDLE;
      end
      M_NAME: begin
        if (is_ws(c) || is_delim(c)) begin
          w = name_flush(w);
          w = done(w, T_NAME);
          w = dispatch(w, c);
        end else begin
          w = name_char(w, c);
        end
      end
      M_CAND: begin
        if (is_digit(c)) begin
          w.st.flags[0] = 1'b1;
          w = content(w, T_NUMBER, c);
        end else if (c == ".") begin
          if (w.st.flags[1]) begin
            w.st.mode = M_KEYWORD;
            w = content(w, T_KEYWORD, c);
          end else begin
            w.st.flags[1] = 1'b1;
            w = content(w, T_NUMBER, c);
          end
        end else if (w.st.flags[0]) begin
          w = put(w, 1'b1, T_NUMBER, 8'd0, !w.st.flags[1]);
          w = dispatch(w, c);
        end else if (is_ws(c) || is_delim(c)) begin
          w = done(w, T_KEYWORD);
          w = dispatch(w, c);
        end else begin
          w.st.mode = M_KEYWORD;
          w = content(w, T_KEYWORD, c);
        end
      end
      M_KEYWORD: begin
        if (is_ws(c) || is_delim(c)) begin
          w = done(w, T_KEYWORD);
          w = dispatch(w, c);
        end else begin
          w = content(w, T_KEYWORD, c);
        end
      end
      M_STR:     w = str_char(w, c);
      M_STR_ESC: w = str_escape(w, c);
      M_STR_CR: begin
        if (c == 8'h0A) w.st.mode = M_STR;
        else w = str_char(w, c);
      end
      M_STR_OCT: begin
        if (c >= "0" && c <= "7") begin
          w.st.escv = {w.st.escv[4:0], c[2:0]};
          w.st.escn = w.st.escn + 2'd1;
          if (w.st.escn == 2'd3) begin
            w = content(w, T_STRING, w.st.escv);
            w.st.escv = 8'd0;
            w.st.escn = 2'd0;
            w.st.mode = M_STR;
          end
        end else begin
          w = content(w, T_STRING, w.st.escv);
          w.st.escv = 8'd0;
          w.st.escn = 2'd0;
          w = str_char(w, c);
        end
      end
      M_LT: begin
        if (c == "<") begin
          w = done(w, T_DICT_START);
          w.st.mode = M_IDLE;
        end else begin
          w.st.mode = M_HEX;
          w.st.nib  = 5'd0;
          w = hex_char(w, c);
        end
      end
      M_GT: begin
        if (c == ">") begin
          w = done(w, T_DICT_END);
          w.st.mode = M_IDLE;
        end else begin
          w = content(w, T_KEYWORD, ">");
          w = done(w, T_KEYWORD);
          w = dispatch(w, c);
        end
      end
      M_HEX:   w = hex_char(w, c);
      default: w = dispatch(w, c);
    endcase
    return w;
  endfunction

  function automatic work_t end_in(work_t w);
    case (w.st.mode)
      M_NAME: begin
        w = name_flush(w);
        w = done(w, T_NAME);
      end
      M_CAND: begin
        if (w.st.flags[0]) w = put(w, 1'b1, T_NUMBER, 8'd0, !w.st.flags[1]);
        else w = done(w, T_KEYWORD);
      end
      M_KEYWORD: w = done(w, T_KEYWORD);
      M_STR, M_STR_ESC, M_STR_CR, M_LT: w = done(w, T_STRING);
      M_STR_OCT: begin
        w = content(w, T_STRING, w.st.escv);
        w = done(w, T_STRING);
      end
      M_GT: begin
        w = content(w, T_KEYWORD, ">");
        w = done(w, T_KEYWORD);
      end
      M_HEX: begin
        if (w.st.nib[4]) w = content(w, T_STRING, {w.st.nib[3:0], 4'd0});
        w = done(w, T_STRING);
      end
      default: begin
      end
    endcase
    w = done(w, T_EOF);
    w.st = '0;
    return w;
  endfunction

endpackage

>>> src/pdf_token_lexer_top.sv
`timescale 1ns / 1ps
// Latency: first result of a transaction is shown the cycle after acceptance when the
// result register is free, else straight after the burst ahead of it.
// Throughput: one input byte per cycle while each yields at most one result and the
// output is not stalled; a byte with more results holds the result register until they
// all leave, one more transaction parks behind it and input stalls only while it waits.
// Reset (rst, synchronous): lexer returns to idle and the result registers empty.
// ---------------------------------------------------------------------------
// pdf_token_lexer_top
// PDF byte-stream tokenizer: lexer step plus result register.
// ---------------------------------------------------------------------------
module pdf_token_lexer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       event_res,
  output logic [3:0] token_type,
  output logic [7:0] content_byte,
  output logic       is_integer,
  output logic       last
);

  ptl_pkg::list_t list;
  logic           load_ok;
  logic           accept;

  assign in_stall = !load_ok;
  assign accept   = in_valid && load_ok;

  ptl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .data_byte (data_byte),
    .list      (list)
  );

  ptl_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .load_req     (accept),
    .list         (list),
    .load_ok      (load_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .token_type   (token_type),
    .content_byte (content_byte),
    .is_integer   (is_integer),
    .last         (last)
  );

endmodule

>>> src/ptl_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptl_core
// Lexer state register and the single-pass byte step that yields the
// result list of one input transaction.
// ---------------------------------------------------------------------------
module ptl_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           kind,
  input  logic [7:0]     data_byte,
  output ptl_pkg::list_t list
);

  ptl_pkg::state_t st;
  ptl_pkg::work_t  w_in;
  ptl_pkg::work_t  w_next;

  // run one byte or end mark through the lexer
  always_comb begin
    w_in.st = st;
    w_in.l  = '0;
    if (kind == ptl_pkg::KIND_END) w_next = ptl_pkg::end_in(w_in);
    else w_next = ptl_pkg::byte_in(w_in, data_byte);
  end

  assign list = w_next.l;

  // advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= w_next.st;
    end
  end

endmodule

>>> src/ptl_burst.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptl_burst
// Result register holding the list of one transaction, plus one parked list
// behind it. Drains one result per cycle while the output is not stalled and
// pulls in the parked list as the final result leaves.
// ---------------------------------------------------------------------------
module ptl_burst (
  input  logic           clk,
  input  logic           rst,
  input  logic           load_req,
  input  ptl_pkg::list_t list,
  output logic           load_ok,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           event_res,
  output logic [3:0]     token_type,
  output logic [7:0]     content_byte,
  output logic           is_integer,
  output logic           last
);

  ptl_pkg::list_t held;
  ptl_pkg::list_t parked;
  logic           parked_full;
  logic [2:0]     rd;
  logic [2:0]     cnt;
  logic           take;
  logic           held_free;
  ptl_pkg::res_t  cur;

  assign out_valid = rd < cnt;
  assign take      = out_valid && !out_stall;
  assign last      = (rd + 3'd1 == cnt);
  assign held_free = !out_valid || (take && last);
  assign load_ok   = !parked_full;
  assign cur       = held.r[rd];

  assign event_res    = cur.ev;
  assign token_type   = cur.ttype;
  assign content_byte = cur.cbyte;
  assign is_integer   = cur.integ;

  // hold payload of the current burst and of the parked transaction
  always_ff @(posedge clk) begin
    if (held_free && parked_full) begin
      held <= parked;
    end else if (held_free && load_req) begin
      held <= list;
    end
    if (!held_free && load_req) begin
      parked <= list;
    end
  end

  // advance read index, reload from the parked list or a new transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      rd          <= 3'd0;
      cnt         <= 3'd0;
      parked_full <= 1'b0;
    end else if (held_free) begin
      rd <= 3'd0;
      if (parked_full) begin
        cnt         <= parked.cnt;
        parked_full <= 1'b0;
      end else if (load_req) begin
        cnt <= list.cnt;
      end else begin
        cnt <= 3'd0;
      end
    end else begin
      if (take) rd <= rd + 3'd1;
      // drop transactions with no result instead of parking them
      if (load_req && list.cnt != 3'd0) parked_full <= 1'b1;
    end
  end

endmodule

>>> src/ptl_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptl_checker
// Port-level checks on the lexer top level, bound to it.
// ---------------------------------------------------------------------------
module ptl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       event_res,
  input logic [3:0] token_type,
  input logic       last
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // nothing is offered straight after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // an empty result register never stalls input
  a_nostall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with nothing pending");

  // final result taken with nothing parked and no new transaction empties the output
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last && !in_stall && !in_valid |=> !out_valid)
    else $error("result invented after last");

  // content bytes belong to number, keyword, name or string
  a_ctype: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_res |-> token_type[3:2] == 2'b00)
    else $error("content with bracket or eof type");

endmodule

bind pdf_token_lexer_top ptl_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .event_res  (event_res),
  .token_type (token_type),
  .last       (last)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PDF token lexer testbench
// Drives a byte stream with end marks into the lexer. A directed table
// covers delimiters, strings, escapes and numbers. Random PDF-like fragments, with
// names and hex strings, and random bytes follow. Every result is checked
// against an in-bench tokenizer model, with random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic       ev;
    logic [3:0] ttype;
    logic [7:0] cbyte;
    logic       integ;
    logic       lst;
  } token_out_t;

  typedef struct packed {
    logic       knd;
    logic [7:0] b;
    logic       has_exp;
    token_out_t exp0;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       kind;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_stall;
  logic       event_res;
  logic [3:0] token_type;
  logic [7:0] content_byte;
  logic       is_integer;
  logic       last;

  pdf_token_lexer_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .data_byte(data_byte), .out_valid(out_valid),
    .out_stall(out_stall), .event_res(event_res), .token_type(token_type),
    .content_byte(content_byte), .is_integer(is_integer), .last(last)
  );

  // Lexer state of the model
  logic [3:0] lx_mode;
  logic [7:0] lx_depth;
  logic [1:0] lx_flags;
  logic [7:0] lx_escv;
  logic [1:0] lx_escn;
  logic [4:0] lx_nib;
  logic [9:0] lx_pname;

  token_out_t step_tokens[$];
  token_out_t token_queue[$];
  int         errors;
  int         n_results;
  int         n_items;
  int         n_eof;
  bit         stim_done;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic bit ws_c(logic [7:0] c);
    return c == 8'h00 || c == 8'h09 || c == 8'h0A || c == 8'h0C ||
           c == 8'h0D || c == 8'h20;
  endfunction

  function automatic bit delim_c(logic [7:0] c);
    return c == "(" || c == ")" || c == "<" || c == ">" || c == "[" ||
           c == "]" || c == "{" || c == "}" || c == "/" || c == "%";
  endfunction

  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - 8'h30;
    if (c >= "a" && c <= "f") return c - 8'h57;
    if (c >= "A" && c <= "F") return c - 8'h37;
    return -1;
  endfunction

  // Append one result, capped at the burst limit
  task automatic emit(logic ev, logic [3:0] t, logic [7:0] b, logic i);
    token_out_t r;
    if (step_tokens.size() < ptl_pkg::NOUT) begin
      r = '{ev: ev, ttype: t, cbyte: b, integ: i, lst: 1'b0};
      step_tokens = {step_tokens, r};
    end
  endtask

  task automatic flush_name();
    if (lx_pname[9:8] >= 2'd1) emit(0, ptl_pkg::T_NAME, "#", 0);
    if (lx_pname[9:8] == 2'd2) emit(0, ptl_pkg::T_NAME, lx_pname[7:0], 0);
    lx_pname = '0;
  endtask

  task automatic start_token(logic [7:0] c);
    lx_mode  = ptl_pkg::M_IDLE;
    lx_flags = '0;
    if (ws_c(c) || c == ")") begin
    end else if (c == "%") lx_mode = ptl_pkg::M_COMMENT;
    else if (c == "/") begin
      lx_mode  = ptl_pkg::M_NAME;
      lx_pname = '0;
    end else if (c == "(") begin
      lx_mode  = ptl_pkg::M_STR;
      lx_depth = 8'd1;
    end else if (c == "<") lx_mode = ptl_pkg::M_LT;
    else if (c == ">") lx_mode = ptl_pkg::M_GT;
    else if (c == "[") emit(1, ptl_pkg::T_ARR_START, 0, 0);
    else if (c == "]") emit(1, ptl_pkg::T_ARR_END, 0, 0);
    else if (c == "{" || c == "}") begin
      emit(0, ptl_pkg::T_KEYWORD, c, 0);
      emit(1, ptl_pkg::T_KEYWORD, 0, 0);
    end else if (c == "+" || c == "-") begin
      lx_mode = ptl_pkg::M_CAND;
      emit(0, ptl_pkg::T_NUMBER, c, 0);
    end else if (c >= "0" && c <= "9") begin
      lx_mode  = ptl_pkg::M_CAND;
      lx_flags = 2'd1;
      emit(0, ptl_pkg::T_NUMBER, c, 0);
    end else if (c == ".") begin
      lx_mode  = ptl_pkg::M_CAND;
      lx_flags = 2'd2;
      emit(0, ptl_pkg::T_NUMBER, c, 0);
    end else begin
      lx_mode = ptl_pkg::M_KEYWORD;
      emit(0, ptl_pkg::T_KEYWORD, c, 0);
    end
  endtask

  task automatic string_byte(logic [7:0] c);
    lx_mode = ptl_pkg::M_STR;
    if (c == "\\") lx_mode = ptl_pkg::M_STR_ESC;
    else if (c == "(") begin
      if (lx_depth < ptl_pkg::MAX_DEPTH) lx_depth++;
      emit(0, ptl_pkg::T_STRING, c, 0);
    end else if (c == ")") begin
      if (lx_depth > 0) lx_depth--;
      if (lx_depth > 0) emit(0, ptl_pkg::T_STRING, c, 0);
      else begin
        emit(1, ptl_pkg::T_STRING, 0, 0);
        lx_mode = ptl_pkg::M_IDLE;
      end
    end else emit(0, ptl_pkg::T_STRING, c, 0);
  endtask

  task automatic hex_byte(logic [7:0] c);
    int v;
    v = hex_of(c);
    if (c == ">") begin
      if (lx_nib[4]) emit(0, ptl_pkg::T_STRING, {lx_nib[3:0], 4'h0}, 0);
      lx_nib = '0;
      emit(1, ptl_pkg::T_STRING, 0, 0);
      lx_mode = ptl_pkg::M_IDLE;
    end else if (v >= 0) begin
      if (lx_nib[4]) begin
        emit(0, ptl_pkg::T_STRING, {lx_nib[3:0], 4'(v)}, 0);
        lx_nib = '0;
      end else lx_nib = {1'b1, 4'(v)};
    end
  endtask

  // Work out the results of one transaction into step_tokens
  task automatic lex_step(logic knd, logic [7:0] c);
    int hv;
    step_tokens.delete();
    if (knd == ptl_pkg::KIND_END) begin
      case (lx_mode)
        ptl_pkg::M_NAME: begin
          flush_name();
          emit(1, ptl_pkg::T_NAME, 0, 0);
        end
        ptl_pkg::M_CAND: begin
          if (lx_flags[0]) emit(1, ptl_pkg::T_NUMBER, 0, !lx_flags[1]);
          else emit(1, ptl_pkg::T_KEYWORD, 0, 0);
        end
        ptl_pkg::M_KEYWORD: emit(1, ptl_pkg::T_KEYWORD, 0, 0);
        ptl_pkg::M_STR, ptl_pkg::M_STR_ESC, ptl_pkg::M_STR_CR, ptl_pkg::M_LT:
          emit(1, ptl_pkg::T_STRING, 0, 0);
        ptl_pkg::M_STR_OCT: begin
          emit(0, ptl_pkg::T_STRING, lx_escv, 0);
          emit(1, ptl_pkg::T_STRING, 0, 0);
        end
        ptl_pkg::M_GT: begin
          emit(0, ptl_pkg::T_KEYWORD, ">", 0);
          emit(1, ptl_pkg::T_KEYWORD, 0, 0);
        end
        ptl_pkg::M_HEX: begin
          if (lx_nib[4]) emit(0, ptl_pkg::T_STRING, {lx_nib[3:0], 4'h0}, 0);
          emit(1, ptl_pkg::T_STRING, 0, 0);
        end
        default: begin
        end
      endcase
      emit(1, ptl_pkg::T_EOF, 0, 0);
      lx_mode = ptl_pkg::M_IDLE; lx_depth = '0; lx_flags = '0; lx_escv = '0;
      lx_escn = '0; lx_nib = '0; lx_pname = '0;
    end else begin
      case (lx_mode)
        ptl_pkg::M_COMMENT: if (c == 8'h0A || c == 8'h0D) lx_mode = ptl_pkg::M_IDLE;
        ptl_pkg::M_NAME: begin
          if (ws_c(c) || delim_c(c)) begin
            flush_name();
            emit(1, ptl_pkg::T_NAME, 0, 0);
            start_token(c);
          end else if (lx_pname[9:8] == 2'd1 && hex_of(c) >= 0) begin
            lx_pname = {2'd2, c};
          end else if (lx_pname[9:8] == 2'd2 && hex_of(c) >= 0) begin
            hv = hex_of(lx_pname[7:0]);
            emit(0, ptl_pkg::T_NAME, {4'(hv), 4'(hex_of(c))}, 0);
            lx_pname = '0;
          end else begin
            flush_name();
            if (c == "#") lx_pname = {2'd1, 8'h00};
            else emit(0, ptl_pkg::T_NAME, c, 0);
          end
        end
        ptl_pkg::M_CAND: begin
          if (c >= "0" && c <= "9") begin
            lx_flags[0] = 1'b1;
            emit(0, ptl_pkg::T_NUMBER, c, 0);
          end else if (c == ".") begin
            if (lx_flags[1]) begin
              lx_mode = ptl_pkg::M_KEYWORD;
              emit(0, ptl_pkg::T_KEYWORD, c, 0);
            end else begin
              lx_flags[1] = 1'b1;
              emit(0, ptl_pkg::T_NUMBER, c, 0);
            end
          end else if (lx_flags[0]) begin
            emit(1, ptl_pkg::T_NUMBER, 0, !lx_flags[1]);
            start_token(c);
          end else if (ws_c(c) || delim_c(c)) begin
            emit(1, ptl_pkg::T_KEYWORD, 0, 0);
            start_token(c);
          end else begin
            lx_mode = ptl_pkg::M_KEYWORD;
            emit(0, ptl_pkg::T_KEYWORD, c, 0);
          end
        end
        ptl_pkg::M_KEYWORD: begin
          if (ws_c(c) || delim_c(c)) begin
            emit(1, ptl_pkg::T_KEYWORD, 0, 0);
            start_token(c);
          end else emit(0, ptl_pkg::T_KEYWORD, c, 0);
        end
        ptl_pkg::M_STR: string_byte(c);
        ptl_pkg::M_STR_ESC: begin
          lx_mode = ptl_pkg::M_STR;
          case (c)
            "n": emit(0, ptl_pkg::T_STRING, 8'h0A, 0);
            "r": emit(0, ptl_pkg::T_STRING, 8'h0D, 0);
            "t": emit(0, ptl_pkg::T_STRING, 8'h09, 0);
            "b": emit(0, ptl_pkg::T_STRING, 8'h08, 0);
            "f": emit(0, ptl_pkg::T_STRING, 8'h0C, 0);
            8'h0D: lx_mode = ptl_pkg::M_STR_CR;
            8'h0A: begin
            end
            default: begin
              if (c >= "0" && c <= "7") begin
                lx_escv = {5'd0, c[2:0]};
                lx_escn = 2'd1;
                lx_mode = ptl_pkg::M_STR_OCT;
              end else emit(0, ptl_pkg::T_STRING, c, 0);
            end
          endcase
        end
        ptl_pkg::M_STR_CR: begin
          if (c == 8'h0A) lx_mode = ptl_pkg::M_STR;
          else string_byte(c);
        end
        ptl_pkg::M_STR_OCT: begin
          if (c >= "0" && c <= "7") begin
            lx_escv = {lx_escv[4:0], c[2:0]};
            lx_escn++;
            if (lx_escn == 2'd3) begin
              emit(0, ptl_pkg::T_STRING, lx_escv, 0);
              lx_escv = '0; lx_escn = '0; lx_mode = ptl_pkg::M_STR;
            end
          end else begin
            emit(0, ptl_pkg::T_STRING, lx_escv, 0);
            lx_escv = '0; lx_escn = '0;
            string_byte(c);
          end
        end
        ptl_pkg::M_LT: begin
          if (c == "<") begin
            emit(1, ptl_pkg::T_DICT_START, 0, 0);
            lx_mode = ptl_pkg::M_IDLE;
          end else begin
            lx_mode = ptl_pkg::M_HEX;
            lx_nib  = '0;
            hex_byte(c);
          end
        end
        ptl_pkg::M_GT: begin
          if (c == ">") begin
            emit(1, ptl_pkg::T_DICT_END, 0, 0);
            lx_mode = ptl_pkg::M_IDLE;
          end else begin
            emit(0, ptl_pkg::T_KEYWORD, ">", 0);
            emit(1, ptl_pkg::T_KEYWORD, 0, 0);
            start_token(c);
          end
        end
        ptl_pkg::M_HEX: hex_byte(c);
        default: start_token(c);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].lst = 1'b1;
  endtask

  // Send one transaction, hold it until taken, then queue its results
  task automatic send_byte(logic knd, logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 1);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= knd;
    data_byte <= b;
    // look at stall mid-cycle, then take the accepting edge
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    lex_step(knd, b);
    token_queue = {token_queue, step_tokens};
    n_items++;
    if (knd == ptl_pkg::KIND_END) n_eof++;
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_byte(ptl_pkg::KIND_DATA, s[k]);
  endtask

  // Check results at each edge
  always @(posedge clk) begin
    token_out_t got;
    token_out_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{ev: event_res, ttype: token_type, cbyte: content_byte,
              integ: is_integer, lst: last};
      n_results++;
      if (token_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = token_queue.pop_front();
        if (got.ev !== want.ev) begin
          $display("%0t: event expected %0d actual %0d", $time, want.ev, got.ev);
          errors++;
        end
        if (got.ttype !== want.ttype) begin
          $display("%0t: type expected %0d actual %0d", $time, want.ttype, got.ttype);
          errors++;
        end
        if (got.cbyte !== want.cbyte) begin
          $display("%0t: byte expected %h actual %h", $time, want.cbyte, got.cbyte);
          errors++;
        end
        if (got.integ !== want.integ) begin
          $display("%0t: integer expected %0d actual %0d", $time, want.integ, got.integ);
          errors++;
        end
        if (got.lst !== want.lst) begin
          $display("%0t: last expected %0d actual %0d", $time, want.lst, got.lst);
          errors++;
        end
      end
    end
  end

  // Stall the result side in random bursts, with calm stretches
  always @(posedge clk) begin
    if (rst || stim_done) out_stall <= 1'b0;
    else if ((n_items / 40) % 3 == 2) out_stall <= 1'b0;
    else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 3) != 0) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 4) == 0);
  end

  stim_row_t plan[$];

  task automatic add_row(logic knd, logic [7:0] b, logic has_exp, token_out_t e);
    stim_row_t row;
    row  = '{knd: knd, b: b, has_exp: has_exp, exp0: e};
    plan = {plan, row};
  endtask

  initial begin
    string frags[$];
    logic [7:0] ch;
    int sel;
    int waited;
    errors = 0; n_results = 0; n_items = 0; n_eof = 0; stim_done = 0;
    lx_mode = ptl_pkg::M_IDLE; lx_depth = '0; lx_flags = '0; lx_escv = '0;
    lx_escn = '0; lx_nib = '0; lx_pname = '0;
    rst = 1'b1; in_valid = 1'b0; kind = ptl_pkg::KIND_DATA; data_byte = 8'h00;
    out_stall = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: end mark after reset, brackets, extremes, escapes
    add_row(ptl_pkg::KIND_END,  8'hFF, 1, '{1, ptl_pkg::T_EOF, 0, 0, 1});
    add_row(ptl_pkg::KIND_DATA, "[", 1, '{1, ptl_pkg::T_ARR_START, 0, 0, 1});
    add_row(ptl_pkg::KIND_DATA, "]", 1, '{1, ptl_pkg::T_ARR_END, 0, 0, 1});
    add_row(ptl_pkg::KIND_DATA, "{", 0, '0);
    add_row(ptl_pkg::KIND_DATA, 8'hFF, 0, '0);
    add_row(ptl_pkg::KIND_DATA, 8'h00, 0, '0);
    add_row(ptl_pkg::KIND_DATA, "<", 0, '0);
    add_row(ptl_pkg::KIND_DATA, "<", 1, '{1, ptl_pkg::T_DICT_START, 0, 0, 1});
    add_row(ptl_pkg::KIND_DATA, ">", 0, '0);
    add_row(ptl_pkg::KIND_DATA, ">", 1, '{1, ptl_pkg::T_DICT_END, 0, 0, 1});
    add_row(ptl_pkg::KIND_DATA, ">", 0, '0);
    add_row(ptl_pkg::KIND_DATA, "1", 0, '0);
    add_row(ptl_pkg::KIND_DATA, ".", 0, '0);
    add_row(ptl_pkg::KIND_DATA, ".", 0, '0);
    add_row(ptl_pkg::KIND_DATA, " ", 0, '0);
    add_row(ptl_pkg::KIND_DATA, "(", 0, '0);
    add_row(ptl_pkg::KIND_DATA, "\\", 0, '0);
    add_row(ptl_pkg::KIND_DATA, "5", 0, '0);
    add_row(ptl_pkg::KIND_DATA, "3", 0, '0);
    add_row(ptl_pkg::KIND_DATA, "\\", 0, '0);
    add_row(ptl_pkg::KIND_END,  8'h00, 0, '0);
    add_row(ptl_pkg::KIND_DATA, "-", 0, '0);
    add_row(ptl_pkg::KIND_END,  8'h00, 0, '0);
    foreach (plan[k]) begin
      if (plan[k].has_exp) begin
        send_byte(plan[k].knd, plan[k].b);
        if (step_tokens.size() != 1 || step_tokens[0] != plan[k].exp0) begin
          $display("%0t: directed row %0d expected %h actual %h", $time, k,
                   plan[k].exp0, step_tokens.size() ? step_tokens[0] : '0);
          errors++;
        end
      end else send_byte(plan[k].knd, plan[k].b);
    end

    // Fragments reaching the deeper states
    frags = '{"/Na#6de#4 ", "/A#x#", "/B#4", "(a(b)c\\n\\r\\t\\b\\f\\q)",
              "(x\\\r\ny\\\nz\\0127\\9)", "<48656c6>", "<4 8g>", "+12 ",
              "-.5/", "3.14[", "..x ", "+x ", "+.)", "% note\r1 ", "true ",
              ">a", "(((()", "<>", "12#", "0.]", "<< /K 5 >>"};
    while (n_items < 160) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) send_text(frags[$urandom_range(0, frags.size() - 1)]);
      else if (sel < 8) begin
        repeat ($urandom_range(1, 6)) begin
          ch = $urandom_range(0, 255);
          send_byte(ptl_pkg::KIND_DATA, ch);
        end
      end else if (sel == 8) send_byte(ptl_pkg::KIND_END, $urandom_range(0, 255));
      else send_byte(ptl_pkg::KIND_DATA, " ");
    end
    // Deep nesting, then an unterminated flush
    send_byte(ptl_pkg::KIND_DATA, "(");
    repeat (40) send_byte(ptl_pkg::KIND_DATA, "(");
    repeat (3) send_byte(ptl_pkg::KIND_DATA, ")");
    send_byte(ptl_pkg::KIND_DATA, "\\");
    send_byte(ptl_pkg::KIND_DATA, "7");
    send_byte(ptl_pkg::KIND_END, 8'h00);
    in_valid <= 1'b0;
    stim_done = 1;

    waited = 0;
    while (token_queue.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (token_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, token_queue.size());
      errors++;
    end
    $display("Sent %0d transactions with %0d end marks; checked %0d results.",
             n_items, n_eof, n_results);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> pdf_token_lexer_top.f
src/ptl_pkg.sv
src/ptl_core.sv
src/ptl_burst.sv
src/pdf_token_lexer_top.sv
src/ptl_checker.sv
bench/tb_top.sv
